>>> rtl/core/i2cm_pkg.sv
// Package: shared types and constants for the I2C master register access block.
`timescale 1ns / 1ps
package i2cm_pkg;

  typedef enum logic [4:0] {
    PH_IDLE      = 5'd0,
    PH_START     = 5'd1,
    PH_ADDRW     = 5'd2,
    PH_ACK_ADDRW = 5'd3,
    PH_INDEX     = 5'd4,
    PH_ACK_INDEX = 5'd5,
    PH_DATA      = 5'd6,
    PH_ACK_DATA  = 5'd7,
    PH_RSTART    = 5'd8,
    PH_ADDRR     = 5'd9,
    PH_ACK_ADDRR = 5'd10,
    PH_RBIT      = 5'd11,
    PH_RACK1     = 5'd12,
    PH_RACK2     = 5'd13,
    PH_STOP_OK   = 5'd14,
    PH_STOP_ADDR = 5'd15,
    PH_STOP_DATA = 5'd16
  } phase_t;

  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_DATA_NACK = 2'd2;

  localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd250;
  localparam logic [1:0] ADDR_DEV = 2'd0;
  localparam logic [1:0] ADDR_TMO = 2'd1;

  // classified request passed from front to back
  typedef struct packed {
    logic       is_tick;
    logic       is_write;
    logic       is_read;
    logic [7:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] read_length;
    logic       sda_in;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic       scl_level;
    logic       sda_release;
    logic [7:0] rx_byte;
    logic       rx_valid;
    logic       rx_last;
    logic       busy_res;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

>>> rtl/core/i2c_master_register_access.sv
// Top level: I2C master register access with stream request/result and APB config.
`timescale 1ns / 1ps
// Each request is one bus tick or a transaction start; one request is taken per
// clock while the queue has room, and each yields exactly one result. A two-entry
// queue separates request decode from the bus sequencer, and an output register
// holds the result, so requests are still taken while a result waits, until the
// queue is full. Registers: device_address at 0x0, ack_timeout at 0x4.
module i2c_master_register_access (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // req_type
  input  logic [31:0] in_tdata,   // reg_index, write_data, read_length, sda_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic        out_tlast,  // rx_last
  output logic [15:0] out_tdata,  // scl_level, sda_release, rx_byte, rx_valid,
                                  // busy_res, done_res, status
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic           cmd_valid, cmd_ready;
  i2cm_pkg::cmd_t cmd;
  i2cm_pkg::res_t res;
  logic [6:0]     dev_r;
  logic [7:0]     tmo_r;
  logic           wr;

  // configuration registers
  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_r <= '0;
      tmo_r <= i2cm_pkg::ACK_TIMEOUT_RESET;
    end else if (wr && cfg_paddr[1:0] == 2'b00) begin
      if (cfg_paddr[2] == i2cm_pkg::ADDR_DEV[0]) dev_r <= cfg_pwdata[6:0];
      else tmo_r <= cfg_pwdata[7:0];
    end
  end
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == i2cm_pkg::ADDR_TMO[0]) cfg_prdata[7:0] = tmo_r;
    else cfg_prdata[6:0] = dev_r;
  end

  i2cm_front u_front (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tuser, .in_tdata,
    .cmd_valid, .cmd_ready, .cmd
  );

  i2cm_back u_back (
    .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd,
    .dev_addr(dev_r), .ack_tmo(tmo_r), .out_tvalid, .out_tready, .res
  );

  assign out_tlast = res.rx_last;
  assign out_tdata = {1'b0, res.status, res.done_res, res.busy_res, res.rx_valid,
                      res.rx_byte, res.sda_release, res.scl_level};

endmodule

>>> rtl/core/i2cm_front.sv
// Front end: accepts requests, decodes the request type and queues them.
`timescale 1ns / 1ps
module i2cm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_tuser,
  input  logic [31:0]       in_tdata,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output i2cm_pkg::cmd_t    cmd
);

  // two-entry queue
  i2cm_pkg::cmd_t q_r [2];
  logic           wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  i2cm_pkg::cmd_t dec;
  logic           push, pop;

  // request decode
  always_comb begin
    dec.is_tick     = (in_tuser == i2cm_pkg::REQ_TICK);
    dec.is_write    = (in_tuser == i2cm_pkg::REQ_WRITE);
    dec.is_read     = (in_tuser == i2cm_pkg::REQ_READ);
    dec.reg_index   = in_tdata[7:0];
    dec.write_data  = in_tdata[15:8];
    dec.read_length = in_tdata[23:16];
    dec.sda_in      = in_tdata[24];
  end

  assign in_tready = (cnt_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (cnt_r != 2'd0);
  assign pop       = cmd_valid && cmd_ready;
  assign cmd       = q_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= dec;
    end
  end

endmodule

>>> rtl/core/i2cm_back.sv
// Back end: I2C sequencer, one request/cycle unless stalled, registered result.
`timescale 1ns / 1ps
module i2cm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  output logic              cmd_ready,
  input  i2cm_pkg::cmd_t    cmd,
  input  logic [6:0]        dev_addr,
  input  logic [7:0]        ack_tmo,
  output logic              out_tvalid,
  input  logic              out_tready,
  output i2cm_pkg::res_t    res
);

  i2cm_pkg::phase_t ph_r, ph_nxt;
  logic       is_read_r, is_read_nxt;
  logic [1:0] tick_r, tick_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] sh_r, sh_nxt;
  logic [7:0] left_r, left_nxt;
  logic [7:0] wait_r, wait_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] dat_r, dat_nxt;
  logic       scl_r, scl_nxt, sda_r, sda_nxt;
  logic       ov_r;
  i2cm_pkg::res_t res_r, rn;
  logic       step;
  logic [8:0] wcnt;
  logic [7:0] left_dec;

  // output register drains when taken
  assign cmd_ready  = !ov_r || out_tready;
  assign step       = cmd_valid && cmd_ready;
  assign out_tvalid = ov_r;
  assign res        = res_r;
  assign wcnt       = {1'b0, wait_r} + 9'd1;
  assign left_dec   = left_r - 8'd1;

  always_comb begin
    ph_nxt = ph_r; is_read_nxt = is_read_r; tick_nxt = tick_r; bit_nxt = bit_r;
    sh_nxt = sh_r; left_nxt = left_r; wait_nxt = wait_r; idx_nxt = idx_r;
    dat_nxt = dat_r; scl_nxt = scl_r; sda_nxt = sda_r;
    rn = '0;

    if (ph_r == i2cm_pkg::PH_IDLE) begin
      if (cmd.is_write || cmd.is_read) begin
        is_read_nxt = cmd.is_read;
        idx_nxt     = cmd.reg_index;
        dat_nxt     = cmd.write_data;
        left_nxt    = cmd.is_read ? cmd.read_length : 8'd0;
        ph_nxt = i2cm_pkg::PH_START; tick_nxt = '0; bit_nxt = '0; sh_nxt = '0;
        wait_nxt = '0;
      end
    end else if (cmd.is_tick) begin
      case (ph_r)
        // start and repeated start
        i2cm_pkg::PH_START, i2cm_pkg::PH_RSTART: begin
          tick_nxt = tick_r + 2'd1;
          case (tick_r)
            2'd0: sda_nxt = 1'b1;
            2'd1: scl_nxt = 1'b1;
            2'd2: sda_nxt = 1'b0;
            default: begin
              scl_nxt = 1'b0; tick_nxt = '0; bit_nxt = '0; wait_nxt = '0;
              if (ph_r == i2cm_pkg::PH_START) begin
                ph_nxt = i2cm_pkg::PH_ADDRW; sh_nxt = {dev_addr, 1'b0};
              end else begin
                ph_nxt = i2cm_pkg::PH_ADDRR; sh_nxt = {dev_addr, 1'b1};
              end
            end
          endcase
        end
        // byte transmit
        i2cm_pkg::PH_ADDRW, i2cm_pkg::PH_INDEX, i2cm_pkg::PH_DATA,
        i2cm_pkg::PH_ADDRR: begin
          tick_nxt = tick_r + 2'd1;
          case (tick_r)
            2'd0: scl_nxt = 1'b0;
            2'd1: sda_nxt = sh_r[7];
            2'd2: scl_nxt = 1'b1;
            default: begin
              scl_nxt = 1'b0; tick_nxt = '0;
              if (bit_r == 3'd7) begin
                ph_nxt = i2cm_pkg::phase_t'(ph_r + 5'd1);
                bit_nxt = '0; sh_nxt = '0; wait_nxt = '0;
              end else begin
                bit_nxt = bit_r + 3'd1; sh_nxt = {sh_r[6:0], 1'b0};
              end
            end
          endcase
        end
        // acknowledge wait
        i2cm_pkg::PH_ACK_ADDRW, i2cm_pkg::PH_ACK_INDEX, i2cm_pkg::PH_ACK_DATA,
        i2cm_pkg::PH_ACK_ADDRR: begin
          if (tick_r == 2'd0) begin
            sda_nxt = 1'b1; tick_nxt = 2'd1;
          end else if (tick_r == 2'd1) begin
            scl_nxt = 1'b1; tick_nxt = 2'd2;
          end else if (!cmd.sda_in || wcnt > {1'b0, ack_tmo}) begin
            if (!cmd.sda_in) scl_nxt = 1'b0;
            tick_nxt = '0; bit_nxt = '0; wait_nxt = '0; sh_nxt = '0;
            case (ph_r)
              i2cm_pkg::PH_ACK_ADDRW:
                if (!cmd.sda_in) begin
                  ph_nxt = i2cm_pkg::PH_INDEX; sh_nxt = idx_r;
                end else ph_nxt = i2cm_pkg::PH_STOP_ADDR;
              i2cm_pkg::PH_ACK_INDEX: begin
                scl_nxt = 1'b0;
                if (is_read_r) ph_nxt = i2cm_pkg::PH_RSTART;
                else begin
                  ph_nxt = i2cm_pkg::PH_DATA; sh_nxt = dat_r;
                end
              end
              i2cm_pkg::PH_ACK_DATA:
                ph_nxt = !cmd.sda_in ? i2cm_pkg::PH_STOP_OK : i2cm_pkg::PH_STOP_DATA;
              default: begin
                scl_nxt = 1'b0;
                ph_nxt = (left_r != 8'd0) ? i2cm_pkg::PH_RBIT : i2cm_pkg::PH_STOP_OK;
              end
            endcase
          end else begin
            wait_nxt = wcnt[7:0];
          end
        end
        // receive bit
        i2cm_pkg::PH_RBIT: begin
          if (tick_r == 2'd0) begin
            scl_nxt = 1'b0; sda_nxt = 1'b1; tick_nxt = 2'd1;
          end else if (tick_r == 2'd1) begin
            tick_nxt = 2'd2;
          end else begin
            scl_nxt = 1'b1;
            sh_nxt = {sh_r[6:0], cmd.sda_in};
            if (bit_r == 3'd7) begin
              rn.rx_byte = {sh_r[6:0], cmd.sda_in};
              rn.rx_valid = 1'b1;
              rn.rx_last = (left_r == 8'd1);
              ph_nxt = i2cm_pkg::PH_RACK1;
              tick_nxt = '0; bit_nxt = '0; sh_nxt = '0; wait_nxt = '0;
            end else begin
              bit_nxt = bit_r + 3'd1; tick_nxt = '0;
            end
          end
        end
        // master ack, first half
        i2cm_pkg::PH_RACK1: begin
          if (tick_r == 2'd0) scl_nxt = 1'b0;
          else if (tick_r == 2'd2) sda_nxt = (left_r == 8'd1);
          if (tick_r == 2'd3) begin
            ph_nxt = i2cm_pkg::PH_RACK2;
            tick_nxt = '0; bit_nxt = '0; sh_nxt = '0; wait_nxt = '0;
          end else tick_nxt = tick_r + 2'd1;
        end
        // master ack, second half
        i2cm_pkg::PH_RACK2: begin
          if (tick_r == 2'd0) begin
            scl_nxt = 1'b1; tick_nxt = 2'd1;
          end else begin
            left_nxt = left_dec;
            ph_nxt = (left_dec != 8'd0) ? i2cm_pkg::PH_RBIT : i2cm_pkg::PH_STOP_OK;
            tick_nxt = '0; bit_nxt = '0; sh_nxt = '0; wait_nxt = '0;
          end
        end
        // stop
        i2cm_pkg::PH_STOP_OK, i2cm_pkg::PH_STOP_ADDR, i2cm_pkg::PH_STOP_DATA: begin
          tick_nxt = tick_r + 2'd1;
          case (tick_r)
            2'd0: scl_nxt = 1'b0;
            2'd1: sda_nxt = 1'b0;
            2'd2: scl_nxt = 1'b1;
            default: begin
              sda_nxt = 1'b1;
              rn.done_res = 1'b1;
              case (ph_r)
                i2cm_pkg::PH_STOP_ADDR: rn.status = i2cm_pkg::ST_ADDR_NACK;
                i2cm_pkg::PH_STOP_DATA: rn.status = i2cm_pkg::ST_DATA_NACK;
                default:                rn.status = i2cm_pkg::ST_OK;
              endcase
              ph_nxt = i2cm_pkg::PH_IDLE;
              tick_nxt = '0; bit_nxt = '0; sh_nxt = '0; wait_nxt = '0;
            end
          endcase
        end
        default: begin
          ph_nxt = i2cm_pkg::PH_IDLE;
          tick_nxt = '0; bit_nxt = '0; sh_nxt = '0; wait_nxt = '0;
        end
      endcase
    end

    rn.scl_level   = scl_nxt;
    rn.sda_release = sda_nxt;
    rn.busy_res    = (ph_nxt != i2cm_pkg::PH_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= i2cm_pkg::PH_IDLE; is_read_r <= 1'b0; tick_r <= '0; bit_r <= '0;
      sh_r <= '0; left_r <= '0; wait_r <= '0; idx_r <= '0; dat_r <= '0;
      scl_r <= 1'b1; sda_r <= 1'b1; ov_r <= 1'b0;
    end else begin
      if (step) begin
        ph_r <= ph_nxt; is_read_r <= is_read_nxt; tick_r <= tick_nxt;
        bit_r <= bit_nxt; sh_r <= sh_nxt; left_r <= left_nxt;
        wait_r <= wait_nxt; idx_r <= idx_nxt; dat_r <= dat_nxt;
        scl_r <= scl_nxt; sda_r <= sda_nxt;
      end
      if (step) ov_r <= 1'b1;
      else if (out_tready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) res_r <= rn;
  end

endmodule

>>> rtl/core/i2cm_checker.sv
// Checker: port-level assertions for the I2C master register access block.
`timescale 1ns / 1ps
module i2cm_props (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic        out_tlast,
  input logic [15:0] out_tdata
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // rx_last only with rx_valid
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tdata[10])
    else $error("rx_last without rx_valid");

  // done ends the transaction
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[12] |-> !out_tdata[11] && out_tdata[1:0] == 2'b11)
    else $error("done while busy or lines not released");

  // status zero unless done
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[12] |-> out_tdata[14:13] == 2'b00)
    else $error("status without done");

endmodule

bind i2c_master_register_access i2cm_props u_chk (
  .clk, .rst_n, .out_tvalid, .out_tready, .out_tlast, .out_tdata
);

>>> tb/i2cm_checker.sv
// Checker: predicts each I2C master result from observed requests and compares it.
`timescale 1ns / 1ps
module i2cm_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic        out_tlast,
  input  logic [15:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending_count
);

  // predictor copy of the sequencer state
  logic [6:0] m_dev;
  logic [7:0] m_tmo;
  i2cm_pkg::phase_t m_ph;
  logic       m_rd;
  logic [1:0] m_tick;
  logic [2:0] m_bit;
  logic [7:0] m_shift, m_left, m_wait, m_idx, m_data;
  logic       m_scl, m_sda;

  i2cm_pkg::res_t bus_results_q[$];

  assign pending_count = bus_results_q.size();

  function automatic logic [7:0] addr_byte(logic rw);
    return {m_dev, rw};
  endfunction

  task automatic go_phase(i2cm_pkg::phase_t ph, logic [7:0] load);
    m_ph = ph; m_tick = '0; m_bit = '0; m_shift = load; m_wait = '0;
  endtask

  task automatic ack_done(logic ok);
    case (m_ph)
      i2cm_pkg::PH_ACK_ADDRW:
        if (ok) go_phase(i2cm_pkg::PH_INDEX, m_idx);
        else go_phase(i2cm_pkg::PH_STOP_ADDR, 8'd0);
      i2cm_pkg::PH_ACK_INDEX: begin
        m_scl = 1'b0;
        if (m_rd) go_phase(i2cm_pkg::PH_RSTART, 8'd0);
        else go_phase(i2cm_pkg::PH_DATA, m_data);
      end
      i2cm_pkg::PH_ACK_DATA:
        go_phase(ok ? i2cm_pkg::PH_STOP_OK : i2cm_pkg::PH_STOP_DATA, 8'd0);
      default: begin
        m_scl = 1'b0;
        go_phase(m_left != 8'd0 ? i2cm_pkg::PH_RBIT : i2cm_pkg::PH_STOP_OK, 8'd0);
      end
    endcase
  endtask

  // advance the model by one request and return the bus result
  task automatic predict_bus_step(input logic [1:0] req, input logic [31:0] d,
                                  output i2cm_pkg::res_t r);
    logic sda;
    int   n;
    sda = d[24];
    r = '0;
    if (m_ph == i2cm_pkg::PH_IDLE) begin
      if (req == i2cm_pkg::REQ_WRITE || req == i2cm_pkg::REQ_READ) begin
        m_rd = (req == i2cm_pkg::REQ_READ);
        m_idx = d[7:0];
        m_data = d[15:8];
        m_left = m_rd ? d[23:16] : 8'd0;
        go_phase(i2cm_pkg::PH_START, 8'd0);
      end
    end else if (req == i2cm_pkg::REQ_TICK) begin
      case (m_ph)
        i2cm_pkg::PH_START, i2cm_pkg::PH_RSTART: begin
          case (m_tick)
            2'd0: m_sda = 1'b1;
            2'd1: m_scl = 1'b1;
            2'd2: m_sda = 1'b0;
            default: ;
          endcase
          if (m_tick == 2'd3) begin
            m_scl = 1'b0;
            if (m_ph == i2cm_pkg::PH_START) go_phase(i2cm_pkg::PH_ADDRW, addr_byte(1'b0));
            else go_phase(i2cm_pkg::PH_ADDRR, addr_byte(1'b1));
          end else m_tick++;
        end
        i2cm_pkg::PH_ADDRW, i2cm_pkg::PH_INDEX, i2cm_pkg::PH_DATA,
        i2cm_pkg::PH_ADDRR: begin
          case (m_tick)
            2'd0: m_scl = 1'b0;
            2'd1: m_sda = m_shift[7];
            2'd2: m_scl = 1'b1;
            default: ;
          endcase
          if (m_tick == 2'd3) begin
            m_scl = 1'b0;
            m_shift = {m_shift[6:0], 1'b0};
            if (m_bit == 3'd7) go_phase(i2cm_pkg::phase_t'(m_ph + 5'd1), 8'd0);
            else begin
              m_bit++; m_tick = '0;
            end
          end else m_tick++;
        end
        i2cm_pkg::PH_ACK_ADDRW, i2cm_pkg::PH_ACK_INDEX, i2cm_pkg::PH_ACK_DATA,
        i2cm_pkg::PH_ACK_ADDRR: begin
          if (m_tick == 2'd0) begin
            m_sda = 1'b1; m_tick = 2'd1;
          end else if (m_tick == 2'd1) begin
            m_scl = 1'b1; m_tick = 2'd2;
          end else if (!sda) begin
            m_scl = 1'b0; ack_done(1'b1);
          end else begin
            n = int'(m_wait) + 1;
            if (n > int'(m_tmo)) ack_done(1'b0);
            else m_wait = n[7:0];
          end
        end
        i2cm_pkg::PH_RBIT: begin
          if (m_tick == 2'd0) begin
            m_scl = 1'b0; m_sda = 1'b1; m_tick = 2'd1;
          end else if (m_tick == 2'd1) m_tick = 2'd2;
          else begin
            m_scl = 1'b1;
            m_shift = {m_shift[6:0], sda};
            if (m_bit == 3'd7) begin
              r.rx_byte = m_shift;
              r.rx_valid = 1'b1;
              r.rx_last = (m_left == 8'd1);
              go_phase(i2cm_pkg::PH_RACK1, 8'd0);
            end else begin
              m_bit++; m_tick = '0;
            end
          end
        end
        i2cm_pkg::PH_RACK1: begin
          if (m_tick == 2'd0) m_scl = 1'b0;
          else if (m_tick == 2'd2) m_sda = (m_left == 8'd1);
          if (m_tick == 2'd3) go_phase(i2cm_pkg::PH_RACK2, 8'd0);
          else m_tick++;
        end
        i2cm_pkg::PH_RACK2: begin
          if (m_tick == 2'd0) begin
            m_scl = 1'b1; m_tick = 2'd1;
          end else begin
            m_left = m_left - 8'd1;
            go_phase(m_left != 8'd0 ? i2cm_pkg::PH_RBIT : i2cm_pkg::PH_STOP_OK, 8'd0);
          end
        end
        i2cm_pkg::PH_STOP_OK, i2cm_pkg::PH_STOP_ADDR, i2cm_pkg::PH_STOP_DATA: begin
          case (m_tick)
            2'd0: m_scl = 1'b0;
            2'd1: m_sda = 1'b0;
            2'd2: m_scl = 1'b1;
            default: begin
              m_sda = 1'b1;
              r.done_res = 1'b1;
              r.status = (m_ph == i2cm_pkg::PH_STOP_OK) ? i2cm_pkg::ST_OK :
                         (m_ph == i2cm_pkg::PH_STOP_ADDR) ? i2cm_pkg::ST_ADDR_NACK :
                         i2cm_pkg::ST_DATA_NACK;
              go_phase(i2cm_pkg::PH_IDLE, 8'd0);
            end
          endcase
          if (m_ph != i2cm_pkg::PH_IDLE) m_tick++;
        end
        default: go_phase(i2cm_pkg::PH_IDLE, 8'd0);
      endcase
    end
    r.scl_level = m_scl;
    r.sda_release = m_sda;
    r.busy_res = (m_ph != i2cm_pkg::PH_IDLE);
  endtask

  always @(posedge clk) begin
    i2cm_pkg::res_t exp_r, got;
    if (!rst_n) begin
      m_dev = '0; m_tmo = i2cm_pkg::ACK_TIMEOUT_RESET; m_rd = 1'b0; m_left = '0;
      m_idx = '0; m_data = '0; m_scl = 1'b1; m_sda = 1'b1;
      go_phase(i2cm_pkg::PH_IDLE, 8'd0);
      bus_results_q.delete();
      fail_count <= 0;
    end else begin
      // register writes
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        if (cfg_paddr[2] == i2cm_pkg::ADDR_DEV[0]) m_dev = cfg_pwdata[6:0];
        else m_tmo = cfg_pwdata[7:0];
      end
      // accepted request
      if (in_tvalid && in_tready) begin
        predict_bus_step(in_tuser, in_tdata, exp_r);
        bus_results_q.push_back(exp_r);
      end
      // accepted result
      if (out_tvalid && out_tready) begin
        got = '{scl_level: out_tdata[0], sda_release: out_tdata[1],
                rx_byte: out_tdata[9:2], rx_valid: out_tdata[10], rx_last: out_tlast,
                busy_res: out_tdata[11], done_res: out_tdata[12],
                status: out_tdata[14:13]};
        if (bus_results_q.size() == 0) begin
          $display("%0t: unexpected result %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = bus_results_q.pop_front();
          if (got !== exp_r) begin
            $display("%0t: mismatch expected %h actual %h", $time, exp_r, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

>>> tb/tb.sv
// Testbench top: drives requests, config writes and backpressure, gives the verdict.
`timescale 1ns / 1ps
module tb;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0, in_tready;
  logic [1:0]  in_tuser = 0;
  logic [31:0] in_tdata = 0;
  logic        out_tvalid, out_tready = 0, out_tlast;
  logic [15:0] out_tdata;
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [2:0]  cfg_paddr = 0;
  logic [31:0] cfg_pwdata = 0, cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending_count;
  int          idle_pct = 14;
  int          hold_cycles = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  i2c_master_register_access i_dut (.*);

  i2cm_checker i_chk (.*);

  // receiver: random stalls, one long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else out_tready <= ($urandom_range(99) >= idle_pct);
  end

  task automatic cfg_write(logic [2:0] addr, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= addr; cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  // called at a clock edge; returns at the edge that takes the request
  task automatic send_request(logic [1:0] req, logic [7:0] idx, logic [7:0] dat,
                              logic [7:0] len, logic sda);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1; in_tuser <= req; in_tdata <= {7'd0, sda, len, dat, idx};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering requests
  task automatic release_bus;
    in_tvalid <= 0;
    @(posedge clk);
  endtask

  // run a transaction: start request then mostly ticks; ack polls answered per mode
  // ack_mode: 0 mostly ack, 1 never ack, 2 random line
  task automatic run_txn(logic [1:0] req, logic [7:0] len, int ack_mode, int max_ticks);
    send_request(req, 8'($urandom), 8'($urandom), len, 1'($urandom_range(1)));
    for (int t = 0; t < max_ticks; t++) begin
      logic s;
      s = (ack_mode == 0) ? ($urandom_range(7) == 0) :
          (ack_mode == 1) ? 1'b1 : 1'($urandom_range(1));
      if ($urandom_range(19) == 0)
        send_request(2'($urandom_range(1, 3)), 8'($urandom), 8'($urandom),
                     8'($urandom), s);
      else send_request(i2cm_pkg::REQ_TICK, 8'd0, 8'd0, 8'd0, s);
    end
  endtask

  task automatic drain;
    release_bus();
    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  initial begin
    #2000000;
    $display("tb failed");
    $finish;
  end

  initial begin
    int n;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed: idle ticks, odd request, extremes, timeout-driven nacks
    cfg_write({i2cm_pkg::ADDR_DEV[0], 2'b00}, 32'h7f);
    cfg_write({i2cm_pkg::ADDR_TMO[0], 2'b00}, 32'd0);
    send_request(i2cm_pkg::REQ_TICK, 8'hff, 8'hff, 8'hff, 1'b1);
    send_request(2'd3, 8'hff, 8'hff, 8'hff, 1'b1);
    run_txn(i2cm_pkg::REQ_WRITE, 8'd0, 1, 30);
    run_txn(i2cm_pkg::REQ_WRITE, 8'd0, 0, 90);
    run_txn(i2cm_pkg::REQ_READ, 8'd0, 0, 140);
    drain();
    cfg_write({i2cm_pkg::ADDR_DEV[0], 2'b00}, 32'd0);
    cfg_write({i2cm_pkg::ADDR_TMO[0], 2'b00}, 32'd255);
    run_txn(i2cm_pkg::REQ_READ, 8'd2, 2, 200);
    // long stall while requests keep coming
    idle_pct = 0;
    hold_cycles <= 300;
    run_txn(i2cm_pkg::REQ_WRITE, 8'd0, 0, 60);
    drain();
    cfg_write({i2cm_pkg::ADDR_TMO[0], 2'b00}, 32'd3);
    idle_pct = 14;
    n = 0;
    while (n < 500) begin
      int k;
      if (n > 200 && n < 300) idle_pct = 0; else idle_pct = 14;
      k = $urandom_range(40, 250);
      run_txn(2'($urandom_range(1, 2)), 8'($urandom_range(0, 3)),
              $urandom_range(0, 2), k);
      n += k;
      if ($urandom_range(3) == 0) begin
        drain();
        cfg_write({i2cm_pkg::ADDR_DEV[0], 2'b00}, $urandom);
        cfg_write({i2cm_pkg::ADDR_TMO[0], 2'b00}, $urandom_range(0, 6));
      end
    end
    drain();
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
